// ===== rtl/bccm_pkg.sv =====
// Shared types and constants for the bounded coin change min/max unit.
// Holds the transaction payload structs, the pipeline work struct and the coin table.
// Has no dependencies; every other file in rtl/ refers to it by scoped names.
package bccm_pkg;

   // Field widths of the transactions.
   localparam int PRICE_W     = 18;
   localparam int CNT_W       = 10;
   localparam int COIN_W      = 13;

   // Internal widths: value sums stay below 2**18 for 10-bit counts.
   localparam int SUM_W       = 18;
   localparam int REM_W       = 8;
   localparam int RECIP_SHIFT = 18;

   // Coin denominations, smallest first.
   localparam int NUM_KINDS   = 5;
   localparam int COIN_VALUE [NUM_KINDS] = '{1, 5, 10, 50, 100};

   // Request transaction payload.
   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic [CNT_W-1:0]   count_1;
      logic [CNT_W-1:0]   count_5;
      logic [CNT_W-1:0]   count_10;
      logic [CNT_W-1:0]   count_50;
      logic [CNT_W-1:0]   count_100;
   } req_type;

   // Response transaction payload.
   typedef struct packed {
      logic              feasible;
      logic [COIN_W-1:0] fewest_coins;
      logic [COIN_W-1:0] most_coins;
   } rsp_type;

   // State of one query as it moves down the pipeline.
   // The f* fields belong to the fewest-coins chain, the m* fields to the most-coins chain.
   typedef struct packed {
      logic [PRICE_W-1:0]                  price;
      logic [NUM_KINDS-1:0][CNT_W-1:0]     cnt;
      logic [NUM_KINDS-2:0][SUM_W-1:0]     below;
      logic [SUM_W-1:0]                    total;
      logic [SUM_W-1:0]                    fp;
      logic [COIN_W-1:0]                   ft;
      logic [SUM_W-1:0]                    fdiff;
      logic                                ftake;
      logic [COIN_W-1:0]                   fq;
      logic [REM_W-1:0]                    fr;
      logic [SUM_W-1:0]                    mp;
      logic [COIN_W-1:0]                   mt;
      logic                                mbad;
      logic                                mgpos;
      logic [SUM_W-1:0]                    mgm1;
      logic [COIN_W-1:0]                   mq;
      logic [REM_W-1:0]                    mr;
   } work_type;

endpackage

// ===== rtl/bounded_coin_change_min_max_unit.sv =====
// Bounded coin change unit: fewest and most coins that pay a price exactly.
// The pipeline has 3 front stages, 4 stages for each of the 4 large denominations,
// and 1 output stage. Throughput is one transaction per cycle unless the response
// is stalled; every stage has its own valid bit, so bubbles close up and new
// requests are taken while a finished response waits.
// Synchronous reset clears the valid bits only; the payload registers are not reset.
module bounded_coin_change_min_max_unit #(
   parameter int COUNT_WIDTH = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bccm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bccm_pkg::rsp_type rsp_data
);

   localparam int NK = bccm_pkg::NUM_KINDS;

   bccm_pkg::work_type link_data [NK];
   logic [NK-1:0]      link_valid;
   logic [NK-1:0]      link_ready;
   logic               front_ready;

   assign req_stall = !front_ready;

   // Capture and prefix sums of value.
   bccm_front #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_data   (req_data),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_data  (link_data[0])
   );

   // One step per large denomination, largest first.
   for (genvar g = 0; g < NK - 1; g++) begin : g_step
      bccm_step #(
         .KIND(NK - 1 - g)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[g]),
         .in_ready  (link_ready[g]),
         .in_data   (link_data[g]),
         .out_valid (link_valid[g+1]),
         .out_ready (link_ready[g+1]),
         .out_data  (link_data[g+1])
      );
   end

   // Ones check and response register.
   bccm_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (link_valid[NK-1]),
      .in_ready  (link_ready[NK-1]),
      .in_data   (link_data[NK-1]),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/bccm_front.sv =====
// Front end of the coin change pipeline: input capture and prefix sums of coin value.
// Three register stages; counts are masked to the configured count width on entry.
// Depends on bccm_pkg.
module bccm_front #(
   parameter int COUNT_WIDTH = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  bccm_pkg::req_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output bccm_pkg::work_type out_data
);

   localparam int CW      = bccm_pkg::CNT_W;
   localparam int SW      = bccm_pkg::SUM_W;
   localparam int EFF_W   = (COUNT_WIDTH < CW) ? COUNT_WIDTH : CW;
   localparam logic [CW-1:0] COUNT_MASK = CW'((2 ** EFF_W) - 1);
   localparam logic [SW-1:0] V5   = SW'(bccm_pkg::COIN_VALUE[1]);
   localparam logic [SW-1:0] V10  = SW'(bccm_pkg::COIN_VALUE[2]);
   localparam logic [SW-1:0] V50  = SW'(bccm_pkg::COIN_VALUE[3]);
   localparam logic [SW-1:0] V100 = SW'(bccm_pkg::COIN_VALUE[4]);

   logic [2:0] vld_ff;
   logic [2:0] vld_in;
   logic [2:0] adv;

   bccm_pkg::work_type f1_ff, f1_in;
   bccm_pkg::work_type f2_ff, f2_in;
   bccm_pkg::work_type f3_ff, f3_in;
   logic [SW-1:0] sum_a_ff, sum_a_in;
   logic [SW-1:0] sum_b_ff, sum_b_in;
   logic [SW-1:0] ten_ff, ten_in;
   logic [SW-1:0] hund_ff, hund_in;

   // A stage moves when it is empty or its successor moves.
   always_comb begin
      adv[2] = !vld_ff[2] || out_ready;
      adv[1] = !vld_ff[1] || adv[2];
      adv[0] = !vld_ff[0] || adv[1];
      vld_in = adv & {vld_ff[1], vld_ff[0], in_valid} | ~adv & vld_ff;
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[2];
   assign out_data  = f3_ff;

   // Stage one: capture the transaction with counts masked.
   always_comb begin
      f1_in        = '0;
      f1_in.price  = in_data.price;
      f1_in.cnt[0] = in_data.count_1   & COUNT_MASK;
      f1_in.cnt[1] = in_data.count_5   & COUNT_MASK;
      f1_in.cnt[2] = in_data.count_10  & COUNT_MASK;
      f1_in.cnt[3] = in_data.count_50  & COUNT_MASK;
      f1_in.cnt[4] = in_data.count_100 & COUNT_MASK;
      f1_in.fp     = SW'(in_data.price);
      f1_in.mp     = SW'(in_data.price);
   end

   // Stage two: coin values per denomination and two partial sums.
   always_comb begin
      f2_in    = f1_ff;
      ten_in   = SW'(f1_ff.cnt[2]) * V10;
      hund_in  = SW'(f1_ff.cnt[4]) * V100;
      sum_a_in = SW'(f1_ff.cnt[0]) + SW'(f1_ff.cnt[1]) * V5;
      sum_b_in = ten_in + SW'(f1_ff.cnt[3]) * V50;
   end

   // Stage three: value covered by all coins below each denomination, and the total.
   always_comb begin
      f3_in          = f2_ff;
      f3_in.below[0] = SW'(f2_ff.cnt[0]);
      f3_in.below[1] = sum_a_ff;
      f3_in.below[2] = sum_a_ff + ten_ff;
      f3_in.below[3] = sum_a_ff + sum_b_ff;
      f3_in.total    = sum_a_ff + sum_b_ff + hund_ff;
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         f1_ff <= f1_in;
      end
      if (adv[1]) begin
         f2_ff    <= f2_in;
         ten_ff   <= ten_in;
         hund_ff  <= hund_in;
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
      end
      if (adv[2]) begin
         f3_ff <= f3_in;
      end
   end

endmodule

// ===== rtl/bccm_step.sv =====
// One denomination of both coin chains: greedy take for the fewest count and
// ceiling take against the value below for the most count. Four register stages.
// Depends on bccm_pkg.
module bccm_step #(
   parameter int KIND = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  bccm_pkg::work_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output bccm_pkg::work_type out_data
);

   localparam int SW    = bccm_pkg::SUM_W;
   localparam int XW    = SW + 1;
   localparam int PW    = 2 * SW;
   localparam int NW    = bccm_pkg::COIN_W;
   localparam int RW    = bccm_pkg::REM_W;
   localparam int SHIFT = bccm_pkg::RECIP_SHIFT;
   localparam int VALUE = bccm_pkg::COIN_VALUE[KIND];
   localparam logic [XW-1:0] VALUE_X = XW'(VALUE);
   localparam logic [RW-1:0] VALUE_R = RW'(VALUE);
   localparam logic [SW-1:0] RECIP   = SW'((2 ** SHIFT) / VALUE);

   logic [3:0] vld_ff;
   logic [3:0] vld_in;
   logic [3:0] adv;

   bccm_pkg::work_type s1_ff, s1_in;
   bccm_pkg::work_type s2_ff, s2_in;
   bccm_pkg::work_type s3_ff, s3_in;
   bccm_pkg::work_type s4_ff, s4_in;

   logic [XW-1:0] f_full;
   logic [XW-1:0] f_diff;
   logic [XW-1:0] m_gap;
   logic [PW-1:0] f_prod;
   logic [PW-1:0] m_prod;
   logic [RW-1:0] f_qv;
   logic [RW-1:0] f_rem;
   logic [RW-1:0] m_qv;
   logic [RW-1:0] m_rem;
   logic [RW-1:0] m_short;
   logic [XW-1:0] m_next;

   // A stage moves when it is empty or its successor moves.
   always_comb begin
      adv[3] = !vld_ff[3] || out_ready;
      adv[2] = !vld_ff[2] || adv[3];
      adv[1] = !vld_ff[1] || adv[2];
      adv[0] = !vld_ff[0] || adv[1];
      vld_in = adv & {vld_ff[2:0], in_valid} | ~adv & vld_ff;
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[3];
   assign out_data  = s4_ff;

   // Stage one: can all coins of this kind be used, and the gap the smaller coins leave.
   always_comb begin
      s1_in      = in_data;
      f_full     = XW'(in_data.cnt[KIND]) * VALUE_X;
      f_diff     = {1'b0, in_data.fp} - f_full;
      s1_in.ftake = !f_diff[SW];
      s1_in.fdiff = f_diff[SW-1:0];
      m_gap      = {1'b0, in_data.mp} - {1'b0, in_data.below[KIND-1]} - XW'(1);
      s1_in.mgpos = in_data.mp > in_data.below[KIND-1];
      s1_in.mgm1  = m_gap[SW-1:0];
   end

   // Stage two: quotient estimates by reciprocal multiplication, low by at most one.
   always_comb begin
      s2_in    = s1_ff;
      f_prod   = PW'(s1_ff.fp) * PW'(RECIP);
      m_prod   = PW'(s1_ff.mgm1) * PW'(RECIP);
      s2_in.fq = f_prod[SHIFT +: NW];
      s2_in.mq = m_prod[SHIFT +: NW];
   end

   // Stage three: remainders from the low bits, then one correction step.
   always_comb begin
      s3_in = s2_ff;
      f_qv  = s2_ff.fq[RW-1:0] * VALUE_R;
      f_rem = s2_ff.fp[RW-1:0] - f_qv;
      m_qv  = s2_ff.mq[RW-1:0] * VALUE_R;
      m_rem = s2_ff.mgm1[RW-1:0] - m_qv;
      s3_in.fr = f_rem;
      s3_in.mr = m_rem;
      if (f_rem >= VALUE_R) begin
         s3_in.fq = s2_ff.fq + NW'(1);
         s3_in.fr = f_rem - VALUE_R;
      end
      if (m_rem >= VALUE_R) begin
         s3_in.mq = s2_ff.mq + NW'(1);
         s3_in.mr = m_rem - VALUE_R;
      end
   end

   // Stage four: update both running amounts and coin totals.
   always_comb begin
      s4_in   = s3_ff;
      m_short = VALUE_R - RW'(1) - s3_ff.mr;
      m_next  = {1'b0, s3_ff.below[KIND-1]} - XW'(m_short);
      if (s3_ff.ftake) begin
         s4_in.fp = s3_ff.fdiff;
         s4_in.ft = s3_ff.ft + NW'(s3_ff.cnt[KIND]);
      end else begin
         s4_in.fp = SW'(s3_ff.fr);
         s4_in.ft = s3_ff.ft + s3_ff.fq;
      end
      // The ceiling take is one more than the floor of (gap - 1) / value.
      if (s3_ff.mgpos) begin
         s4_in.mt   = s3_ff.mt + s3_ff.mq + NW'(1);
         s4_in.mp   = m_next[SW-1:0];
         s4_in.mbad = s3_ff.mbad || m_next[SW];
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_ff <= s1_in;
      end
      if (adv[1]) begin
         s2_ff <= s2_in;
      end
      if (adv[2]) begin
         s3_ff <= s3_in;
      end
      if (adv[3]) begin
         s4_ff <= s4_in;
      end
   end

endmodule

// ===== rtl/bccm_finish.sv =====
// Last stage of the coin change pipeline: ones check, feasibility and the output register.
// One register stage that also serves as the response register.
// Depends on bccm_pkg.
module bccm_finish (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  bccm_pkg::work_type in_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output bccm_pkg::rsp_type  rsp_data
);

   localparam int SW = bccm_pkg::SUM_W;
   localparam int NW = bccm_pkg::COIN_W;

   logic              vld_ff, vld_in;
   logic              adv;
   bccm_pkg::rsp_type rsp_ff, rsp_in;

   logic too_little;
   logic few_short;
   logic most_short;

   // The register moves when it is empty or its transaction is taken.
   always_comb begin
      adv    = !vld_ff || !rsp_stall;
      vld_in = adv ? in_valid : vld_ff;
   end

   assign in_ready  = adv;
   assign rsp_valid = vld_ff;
   assign rsp_data  = rsp_ff;

   // Both chains finish with ones; any shortfall zeroes the result.
   always_comb begin
      too_little = in_data.total < SW'(in_data.price);
      few_short  = in_data.fp > SW'(in_data.cnt[0]);
      most_short = in_data.mbad || (in_data.mp > SW'(in_data.cnt[0]));
      rsp_in     = '0;
      if (!too_little && !few_short && !most_short) begin
         rsp_in.feasible     = 1'b1;
         rsp_in.fewest_coins = in_data.ft + in_data.fp[NW-1:0];
         rsp_in.most_coins   = in_data.mt + in_data.mp[NW-1:0];
      end
   end

   // Valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== sim/tb_bounded_coin_change_min_max_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the bounded coin change min/max unit.
// Depends on rtl/bccm_pkg.sv and rtl/bounded_coin_change_min_max_unit.sv.
module tb_bounded_coin_change_min_max_unit;

   typedef logic [bccm_pkg::PRICE_W-1:0] price_type;
   typedef logic [bccm_pkg::CNT_W-1:0]   count_type;
   typedef logic [bccm_pkg::COIN_W-1:0]  coins_type;

   // Which path through the payment decision a request takes.
   typedef enum int {
      PAY_OK,
      PAY_SHORT_VALUE,
      PAY_SHORT_ONES,
      PAY_OVERSHOOT
   } pay_case_type;

   localparam longint COIN_WORTH [5] = '{1, 5, 10, 50, 100};
   localparam int     DIRECTED_COUNT = 15;
   localparam int     PHASE_ITEMS = 150;
   localparam int     DRAIN_CYCLES = 40;

   // Scoreboard: predicts each accepted request and checks responses in order.
   class coin_change_scoreboard;
      bccm_pkg::rsp_type expected_results[$];
      int mismatches;

      function new();
         mismatches = 0;
      endfunction

      // Fewest and most coins paying the price, with the path taken.
      static function bccm_pkg::rsp_type predict(bccm_pkg::req_type item,
                                                 output pay_case_type why);
         longint cnt [5];
         longint below [5];
         longint left;
         longint fewest_sum;
         longint most_sum;
         longint full;
         longint gap;
         longint take;
         int k;
         bccm_pkg::rsp_type result;
         result = '0;
         why = PAY_OK;
         cnt[0] = longint'(item.count_1);
         cnt[1] = longint'(item.count_5);
         cnt[2] = longint'(item.count_10);
         cnt[3] = longint'(item.count_50);
         cnt[4] = longint'(item.count_100);
         below[0] = cnt[0];
         for (k = 1; k < 5; k++) begin
            below[k] = below[k-1] + cnt[k] * COIN_WORTH[k];
         end
         if (below[4] < longint'(item.price)) begin
            why = PAY_SHORT_VALUE;
            return result;
         end

         // Fewest: take large coins greedily up to the supply.
         left = longint'(item.price);
         fewest_sum = 0;
         for (k = 4; k >= 1; k--) begin
            full = cnt[k] * COIN_WORTH[k];
            if (left >= full) begin
               fewest_sum += cnt[k];
               left -= full;
            end else begin
               fewest_sum += left / COIN_WORTH[k];
               left = left % COIN_WORTH[k];
            end
         end
         if (left > cnt[0]) begin
            why = PAY_SHORT_ONES;
            return result;
         end
         fewest_sum += left;

         // Most: use a large coin only for what the smaller coins cannot cover.
         left = longint'(item.price);
         most_sum = 0;
         for (k = 4; k >= 1; k--) begin
            gap = left - below[k-1];
            if (gap > 0) begin
               take = (gap + COIN_WORTH[k] - 1) / COIN_WORTH[k];
               most_sum += take;
               left -= take * COIN_WORTH[k];
               if (left < 0) begin
                  why = PAY_OVERSHOOT;
                  return result;
               end
            end
         end
         if (left > cnt[0]) begin
            why = PAY_SHORT_ONES;
            return result;
         end
         most_sum += left;

         result.feasible = 1'b1;
         result.fewest_coins = coins_type'(fewest_sum);
         result.most_coins = coins_type'(most_sum);
         return result;
      endfunction

      function void note_request(bccm_pkg::req_type item);
         pay_case_type why;
         expected_results.push_back(predict(item, why));
      endfunction

      function void compare_field(string field, int expected, int actual);
         if (expected != actual) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, expected, actual);
            mismatches++;
         end
      endfunction

      function void check_response(bccm_pkg::rsp_type actual);
         bccm_pkg::rsp_type expected;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, actual);
            mismatches++;
            return;
         end
         expected = expected_results.pop_front();
         compare_field("feasible", int'(expected.feasible), int'(actual.feasible));
         compare_field("fewest_coins", int'(expected.fewest_coins),
                       int'(actual.fewest_coins));
         compare_field("most_coins", int'(expected.most_coins), int'(actual.most_coins));
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   bccm_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   bccm_pkg::rsp_type rsp_data;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   coin_change_scoreboard sb = new();

   bounded_coin_change_min_max_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver backpressure at the current phase's rate.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   // Monitor both channels; values are sampled as they stood before the edge.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         sb.note_request(req_data);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_data);
      end
   end

   function automatic bccm_pkg::req_type make_req(int price, int c1, int c5, int c10,
                                                  int c50, int c100);
      bccm_pkg::req_type item;
      item.price = price_type'(price);
      item.count_1 = count_type'(c1);
      item.count_5 = count_type'(c5);
      item.count_10 = count_type'(c10);
      item.count_50 = count_type'(c50);
      item.count_100 = count_type'(c100);
      return item;
   endfunction

   function automatic longint total_value(bccm_pkg::req_type item);
      return longint'(item.count_1) + 5 * longint'(item.count_5)
           + 10 * longint'(item.count_10) + 50 * longint'(item.count_50)
           + 100 * longint'(item.count_100);
   endfunction

   // Search small supplies for a request that takes the wanted path.
   function automatic bccm_pkg::req_type seek_case(pay_case_type target);
      bccm_pkg::req_type item;
      pay_case_type why;
      bccm_pkg::rsp_type unused;
      int tries;
      for (tries = 0; tries < 20000; tries++) begin
         item = make_req(0, $urandom_range(0, 6), $urandom_range(0, 6),
                         $urandom_range(0, 6), $urandom_range(0, 3), $urandom_range(0, 3));
         item.price = price_type'($urandom_range(0, int'(total_value(item)) + 3));
         unused = coin_change_scoreboard::predict(item, why);
         if (why == target) begin
            return item;
         end
      end
      return item;
   endfunction

   // Counts drawn from a few size classes, extremes included.
   function automatic count_type random_count();
      case ($urandom_range(0, 3))
         0: return count_type'($urandom_range(0, 4));
         1: return count_type'($urandom_range(0, 40));
         2: return count_type'($urandom_range(0, 1023));
         default: return $urandom_range(0, 1) ? '1 : '0;
      endcase
   endfunction

   // Mostly payable prices, then near-total, over-total and fully random ones.
   function automatic bccm_pkg::req_type random_request();
      bccm_pkg::req_type item;
      longint total;
      int unsigned style;
      style = $urandom_range(0, 99);
      item.count_1 = random_count();
      item.count_5 = random_count();
      item.count_10 = random_count();
      item.count_50 = random_count();
      item.count_100 = random_count();
      if (style >= 65 && style < 80) begin
         item.count_1 = count_type'($urandom_range(0, 8));
      end
      total = total_value(item);
      if (style < 65) begin
         item.price = price_type'($urandom_range(0, int'(total)));
      end else if (style < 80) begin
         item.price = price_type'(total - longint'($urandom_range(0, 20)));
         if (total < 20) begin
            item.price = price_type'($urandom_range(0, int'(total)));
         end
      end else if (style < 90) begin
         item.price = price_type'(total + longint'($urandom_range(1, 50)));
      end else begin
         item.price = price_type'($urandom());
      end
      return item;
   endfunction

   // Present one transaction and hold it until the unit takes it.
   task automatic send_item(bccm_pkg::req_type item);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_random(int count);
      int i;
      for (i = 0; i < count; i++) begin
         send_item(random_request());
      end
   endtask

   // Main sequence: reset, directed cases, then three random phases with different idle and stall rates.
   initial begin
      bccm_pkg::req_type directed [DIRECTED_COUNT];
      int i;
      directed[0]  = make_req(0, 0, 0, 0, 0, 0);
      directed[1]  = make_req(0, 1023, 1023, 1023, 1023, 1023);
      directed[2]  = make_req(1, 0, 0, 0, 0, 0);
      directed[3]  = make_req(262143, 1023, 1023, 1023, 1023, 1023);
      directed[4]  = make_req(169818, 1023, 1023, 1023, 1023, 1023);
      directed[5]  = make_req(169817, 1023, 1023, 1023, 1023, 1023);
      directed[6]  = make_req(100, 0, 0, 0, 0, 1);
      directed[7]  = make_req(50, 0, 0, 0, 1, 0);
      directed[8]  = make_req(3, 2, 1, 0, 0, 0);
      directed[9]  = make_req(60, 0, 0, 3, 1, 0);
      directed[10] = make_req(1023, 1023, 0, 0, 0, 0);
      directed[11] = make_req('h2AAAA, 'h155, 'h2AA, 'h155, 'h2AA, 'h155);
      directed[12] = make_req('h15555, 'h2AA, 'h155, 'h2AA, 'h155, 'h2AA);
      directed[13] = seek_case(PAY_SHORT_ONES);
      directed[14] = seek_case(PAY_OVERSHOOT);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 11;
      receiver_stall_pct <= 56;
      for (i = 0; i < DIRECTED_COUNT; i++) begin
         send_item(directed[i]);
      end
      send_random(PHASE_ITEMS);

      sender_idle_pct = 56;
      receiver_stall_pct <= 11;
      send_random(PHASE_ITEMS);

      sender_idle_pct = 0;
      receiver_stall_pct <= 0;
      send_random(PHASE_ITEMS);
      req_valid <= 1'b0;

      // Drain outstanding responses, then watch for stray ones.
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0) begin
         $display("bounded_coin_change_min_max_unit regression: pass");
      end else begin
         $display("bounded_coin_change_min_max_unit regression: fail");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2000000;
      $display("bounded_coin_change_min_max_unit regression: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/bccm_pkg.sv
rtl/bccm_front.sv
rtl/bccm_step.sv
rtl/bccm_finish.sv
rtl/bounded_coin_change_min_max_unit.sv
sim/tb_bounded_coin_change_min_max_unit.sv
